### src/acc_pkg.sv
package acc_pkg;

    // APB register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef enum logic [0:0] {
        REG_PROFILE = 1'b0
    } reg_idx_t;

    // card profiles
    typedef enum logic [1:0] {
        PROF_ISO  = 2'd0,
        PROF_GSM  = 2'd1,
        PROF_UICC = 2'd2,
        PROF_USIM = 2'd3
    } profile_t;

    // command header as carried through the pipeline
    typedef struct packed {
        logic [7:0] cla;
        logic [7:0] ins;
        logic [7:0] p1;
        logic [7:0] p2;
    } hdr_t;

    // result codes
    localparam logic [2:0] CASE_NONE = 3'd0;
    localparam logic [2:0] CASE_1    = 3'd1;
    localparam logic [2:0] CASE_2    = 3'd2;
    localparam logic [2:0] CASE_3    = 3'd3;
    localparam logic [2:0] CASE_4    = 3'd4;

    // table value that hands off to the secure channel / transact data rules
    localparam logic [7:0] HAND_OFF  = 8'h80;
    localparam logic [7:0] VAL_NONE  = 8'h00;
    localparam logic [7:0] VAL_1     = 8'h01;
    localparam logic [7:0] VAL_2     = 8'h02;
    localparam logic [7:0] VAL_3     = 8'h03;
    localparam logic [7:0] VAL_4     = 8'h04;

    localparam logic [7:0] INS_MSC   = 8'h73;   // MANAGE SECURE CHANNEL
    localparam logic [7:0] INS_TD    = 8'h75;   // TRANSACT DATA

    typedef enum logic [2:0] {
        TBL_ISO  = 3'd0,
        TBL_GSM  = 3'd1,
        TBL_U046 = 3'd2,
        TBL_U8CE = 3'd3,
        TBL_U80  = 3'd4
    } tbl_id_t;

    typedef struct packed {
        logic [7:0] cla;
        logic [7:0] mask;
        tbl_id_t    tbl;
    } entry_t;

    localparam int NUM_ENTRIES = 20;
    localparam int MAX_SCAN    = 8;
    localparam int ENT_IDX_W   = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_SCAN + 1);

    localparam entry_t ENTRIES [NUM_ENTRIES] = '{
        // ISO 7816-4
        '{8'h00, 8'hF0, TBL_ISO},  '{8'h80, 8'hE0, TBL_ISO},
        '{8'hB0, 8'hF0, TBL_ISO},  '{8'hC0, 8'hF0, TBL_ISO},
        // GSM 11.11
        '{8'hA0, 8'hFF, TBL_GSM},
        // UICC
        '{8'h80, 8'hFF, TBL_U80},  '{8'h00, 8'hF0, TBL_U046},
        '{8'h40, 8'hF0, TBL_U046}, '{8'h60, 8'hF0, TBL_U046},
        '{8'h80, 8'hF0, TBL_U8CE}, '{8'hC0, 8'hF0, TBL_U8CE},
        '{8'hE0, 8'hF0, TBL_U8CE},
        // UICC plus SIM
        '{8'hA0, 8'hFF, TBL_GSM},  '{8'h80, 8'hFF, TBL_U80},
        '{8'h00, 8'hF0, TBL_U046}, '{8'h40, 8'hF0, TBL_U046},
        '{8'h60, 8'hF0, TBL_U046}, '{8'h80, 8'hF0, TBL_U8CE},
        '{8'hC0, 8'hF0, TBL_U8CE}, '{8'hE0, 8'hF0, TBL_U8CE}
    };

    localparam logic [ENT_IDX_W-1:0] PROF_FIRST [4] = '{5'd0, 5'd4, 5'd5, 5'd12};
    localparam logic [CNT_W-1:0]     PROF_COUNT [4] = '{4'd4, 4'd1, 4'd7, 4'd8};

    // instruction tables
    function automatic logic [7:0] tbl_iso(input logic [7:0] ins);
        case (ins) inside
            8'hB0, 8'hB2, 8'hCA, 8'h84, 8'h70: tbl_iso = VAL_2;
            8'hD0, 8'hD6, 8'h0E, 8'hD2, 8'hE2, 8'hDC,
            8'hDA, 8'h20, 8'h82:               tbl_iso = VAL_3;
            8'hA4, 8'h88:                      tbl_iso = VAL_4;
            default:                           tbl_iso = VAL_NONE;
        endcase
    endfunction

    function automatic logic [7:0] tbl_gsm(input logic [7:0] ins);
        case (ins) inside
            8'h04, 8'h44, 8'hFA:               tbl_gsm = VAL_1;
            8'hF2, 8'hB0, 8'hB2, 8'hC0, 8'h12: tbl_gsm = VAL_2;
            8'hD6, 8'hDC, 8'h20, 8'h24, 8'h26, 8'h28,
            8'h2C, 8'h10, 8'h14:               tbl_gsm = VAL_3;
            8'hA4, 8'hA2, 8'h32, 8'h88, 8'hC2: tbl_gsm = VAL_4;
            default:                           tbl_gsm = VAL_NONE;
        endcase
    endfunction

    function automatic logic [7:0] tbl_u046(input logic [7:0] ins);
        case (ins) inside
            8'h04, 8'h44:                      tbl_u046 = VAL_1;
            8'hB0, 8'hB2, 8'h84, 8'h70, 8'hC0: tbl_u046 = VAL_2;
            8'hD6, 8'hDC, 8'h20, 8'h24, 8'h26, 8'h28,
            8'h2C:                             tbl_u046 = VAL_3;
            8'hA4, 8'hA2, 8'h88, 8'h89:        tbl_u046 = VAL_4;
            INS_MSC, INS_TD:                   tbl_u046 = HAND_OFF;
            default:                           tbl_u046 = VAL_NONE;
        endcase
    endfunction

    function automatic logic [7:0] tbl_u8ce(input logic [7:0] ins);
        case (ins) inside
            8'hF2:        tbl_u8ce = VAL_2;
            8'hDB, 8'hAA: tbl_u8ce = VAL_3;
            8'h32, 8'hCB: tbl_u8ce = VAL_4;
            default:      tbl_u8ce = VAL_NONE;
        endcase
    endfunction

    function automatic logic [7:0] tbl_u80(input logic [7:0] ins);
        case (ins) inside
            8'h12:        tbl_u80 = VAL_2;
            8'h10, 8'h14: tbl_u80 = VAL_3;
            8'hC2:        tbl_u80 = VAL_4;
            default:      tbl_u80 = VAL_NONE;
        endcase
    endfunction

    function automatic logic [7:0] tbl_lookup(input tbl_id_t tbl, input logic [7:0] ins);
        unique case (tbl)
            TBL_ISO:  tbl_lookup = tbl_iso(ins);
            TBL_GSM:  tbl_lookup = tbl_gsm(ins);
            TBL_U046: tbl_lookup = tbl_u046(ins);
            TBL_U8CE: tbl_lookup = tbl_u8ce(ins);
            default:  tbl_lookup = tbl_u80(ins);
        endcase
    endfunction

endpackage

### src/acc_if.sv
// command header channel
interface acc_hdr_if;
    logic       valid;
    logic       ready;
    logic [7:0] class_byte;
    logic [7:0] instr_byte;
    logic [7:0] param_one;
    logic [7:0] param_two;

    modport source (
        output valid, class_byte, instr_byte, param_one, param_two,
        input  ready
    );
    modport sink (
        input  valid, class_byte, instr_byte, param_one, param_two,
        output ready
    );
endinterface

// case result channel
interface acc_case_if;
    logic       valid;
    logic       ready;
    logic [2:0] apdu_case;

    modport source (
        output valid, apdu_case,
        input  ready
    );
    modport sink (
        input  valid, apdu_case,
        output ready
    );
endinterface

### src/apdu_case_classifier_top.sv
// APDU case classifier.
// Path: an accepted header goes to the input register, its case then to the result register.
// Throughput: 1 header per cycle; the input register refills whenever the result
// register is empty or its item is taken in the same cycle.
// Reset: rst_n clears both pipeline valid flags and sets the profile to ISO 7816-4.
module apdu_case_classifier_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [acc_pkg::ADDR_W-1:0] paddr,
    input  logic [acc_pkg::DATA_W-1:0] pwdata,
    output logic [acc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    acc_hdr_if.sink                    hdr_in,
    acc_case_if.source                 case_out
);

    acc_pkg::profile_t profile;
    acc_pkg::hdr_t     hdr_in_word;
    logic [2:0]        case_comb;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    acc_pkg::hdr_t     s1_hdr_reg;
    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic [2:0]        s2_case_reg;
    logic              s1_load;
    logic              s2_load;

    acc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .profile (profile)
    );

    // pipeline handshake
    assign s2_load      = s1_valid_reg && (!s2_valid_reg || case_out.ready);
    assign hdr_in.ready = !s1_valid_reg || s2_load;
    assign s1_load      = hdr_in.valid && hdr_in.ready;

    assign hdr_in_word = '{cla: hdr_in.class_byte, ins: hdr_in.instr_byte,
                           p1: hdr_in.param_one, p2: hdr_in.param_two};

    always_comb
    begin
        s1_valid_next = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_reg);
        s2_valid_next = s2_load ? 1'b1 : (case_out.ready ? 1'b0 : s2_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_hdr_reg <= hdr_in_word;
        end
        if (s2_load)
        begin
            s2_case_reg <= case_comb;
        end
    end

    acc_classify u_classify (
        .profile   (profile),
        .hdr       (s1_hdr_reg),
        .apdu_case (case_comb)
    );

    assign case_out.valid     = s2_valid_reg;
    assign case_out.apdu_case = s2_case_reg;

endmodule

### src/acc_cfg.sv
module acc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [acc_pkg::ADDR_W-1:0] paddr,
    input  logic [acc_pkg::DATA_W-1:0] pwdata,
    output logic [acc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output acc_pkg::profile_t          profile
);

    acc_pkg::profile_t profile_reg;
    acc_pkg::profile_t profile_next;
    logic              sel_profile;

    // word index sits above the byte offset
    assign sel_profile = (acc_pkg::reg_idx_t'(paddr[2]) == acc_pkg::REG_PROFILE);

    always_comb
    begin
        profile_next = profile_reg;
        if (psel && penable && pwrite && sel_profile)
        begin
            profile_next = acc_pkg::profile_t'(pwdata[1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_reg <= acc_pkg::PROF_ISO;
        end
        else
        begin
            profile_reg <= profile_next;
        end
    end

    // readback
    assign prdata  = sel_profile ? {{(acc_pkg::DATA_W-2){1'b0}}, profile_reg}
                                 : '0;
    assign pready  = 1'b1;
    assign profile = profile_reg;

endmodule

### src/acc_classify.sv
module acc_classify (
    input  acc_pkg::profile_t profile,
    input  acc_pkg::hdr_t     hdr,
    output logic [2:0]        apdu_case
);

    // secure channel / transact data rules; their answer is final
    function automatic logic [2:0] hand_off_rule(input logic [7:0] ins,
                                                 input logic [7:0] p1,
                                                 input logic [7:0] p2);
        logic [2:0] top;
        top = p2[7:5];
        hand_off_rule = acc_pkg::CASE_NONE;
        if (ins == acc_pkg::INS_MSC)
        begin
            if (p1 == 8'h00)
            begin
                hand_off_rule = acc_pkg::CASE_2;
            end
            else
            begin
                case (p1[2:0]) inside
                    3'd1, 3'd2, 3'd3:
                    begin
                        if (p2 == 8'h80 || top == 3'd0)
                        begin
                            hand_off_rule = acc_pkg::CASE_3;
                        end
                        else if (top == 3'd5 || top == 3'd1)
                        begin
                            hand_off_rule = acc_pkg::CASE_2;
                        end
                    end
                    3'd4:    hand_off_rule = acc_pkg::CASE_3;
                    default: hand_off_rule = acc_pkg::CASE_NONE;
                endcase
            end
        end
        else if (ins == acc_pkg::INS_TD)
        begin
            hand_off_rule = p1[2] ? acc_pkg::CASE_3 : acc_pkg::CASE_2;
        end
    endfunction

    // priority scan over the profile's entries, first nonzero hit wins
    always_comb
    begin
        logic                             found;
        logic [2:0]                       res;
        logic [acc_pkg::ENT_IDX_W-1:0]    first;
        logic [acc_pkg::CNT_W-1:0]        count;
        logic [acc_pkg::ENT_IDX_W-1:0]    idx;
        acc_pkg::entry_t                  ent;
        logic [7:0]                       val;
        found = 1'b0;
        res   = acc_pkg::CASE_NONE;
        first = acc_pkg::PROF_FIRST[profile];
        count = acc_pkg::PROF_COUNT[profile];
        for (int i = 0; i < acc_pkg::MAX_SCAN; i++)
        begin
            idx = first + acc_pkg::ENT_IDX_W'(i);
            ent = acc_pkg::ENTRIES[idx];
            val = acc_pkg::tbl_lookup(ent.tbl, hdr.ins);
            if (!found && (acc_pkg::CNT_W'(i) < count)
                && ((hdr.cla & ent.mask) == ent.cla) && (val != acc_pkg::VAL_NONE))
            begin
                found = 1'b1;
                if (val == acc_pkg::HAND_OFF)
                begin
                    res = hand_off_rule(hdr.ins, hdr.p1, hdr.p2);
                end
                else
                begin
                    res = val[2:0];
                end
            end
        end
        apdu_case = res;
    end

endmodule
